/* rtl/mlfs_pkg.sv */
// ----------------------------------------------------------------------------
// mlfs_pkg
// Shared types and constants of the multilevel feedback scheduler.
// ----------------------------------------------------------------------------
package mlfs_pkg;

   localparam int THREADS     = 16;
   localparam int LEVELS      = 4;
   localparam int TID_W       = $clog2(THREADS);
   localparam int LVL_W       = $clog2(LEVELS);
   localparam int ACTION_W    = 3;
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 8;

   localparam logic [ACTION_W-1:0] ACT_ADMIT = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_TICK  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_YIELD = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_LEAVE = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_WAKE  = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_SETLV = 3'd5;

   localparam logic [CSR_ADDR_W-1:0] CSR_BOOST_INTERVAL = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_INITIAL_LEVEL  = 1'd1;

   localparam logic [7:0]       BOOST_RESET = 8'd10;
   localparam logic [LVL_W-1:0] LEVEL_RESET = LVL_W'(LEVELS - 1);

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request and apply the event step
      logic grant;     // pop highest nonempty level
      logic boost;     // splice one lower level onto the top
      logic [LVL_W-1:0] boost_level;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_grant;
      logic boost_due;
   } status_type;

endpackage

/* rtl/mlfs_ctrl.sv */
// ----------------------------------------------------------------------------
// mlfs_ctrl
// Sequencer: event step, optional grant, boost sweep over lower levels, reply.
// ----------------------------------------------------------------------------
module mlfs_ctrl
   import mlfs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_GRANT = 4'b0010,
      ST_BOOST = 4'b0100,
      ST_RESP  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

   always_comb begin
      state_in = state_ff;
      lvl_in   = lvl_ff;
      cmd      = '0;
      cmd.boost_level = lvl_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_GRANT;
            end
         end
         ST_GRANT: begin
            if (status.need_grant) begin
               cmd.grant = 1'b1;
            end
            if (status.need_grant && status.boost_due) begin
               lvl_in   = '0;
               state_in = ST_BOOST;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_BOOST: begin
            cmd.boost = 1'b1;
            lvl_in    = lvl_ff + 1'b1;
            if (lvl_ff == LVL_W'(LEVELS - 2)) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lvl_ff   <= '0;
      end else begin
         state_ff <= state_in;
         lvl_ff   <= lvl_in;
      end
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_boost_resp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BOOST && lvl_ff == LVL_W'(LEVELS - 2) |=> state_ff == ST_RESP)
      else $error("boost sweep overran");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_GRANT)
      else $error("load without grant step");

endmodule

/* rtl/mlfs_dp.sv */
// ----------------------------------------------------------------------------
// mlfs_dp
// Queue lists, thread levels, running thread and grant counter.
// ----------------------------------------------------------------------------
module mlfs_dp
   import mlfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [ACTION_W-1:0]   req_action,
   input  logic [TID_W-1:0]      req_thread_id,
   input  logic [LVL_W-1:0]      req_new_level,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic [TID_W-1:0]      rsp_run_thread,
   output logic                  rsp_run_valid,
   output logic                  rsp_switched,
   output logic                  rsp_boosted
);

   logic [TID_W-1:0] link_ff   [THREADS];
   logic [LVL_W-1:0] level_ff  [THREADS];
   logic [LVL_W-1:0] qlv_ff    [THREADS];
   logic [TID_W-1:0] head_ff   [LEVELS];
   logic [TID_W-1:0] tail_ff   [LEVELS];
   logic [LEVELS-1:0]  nonempty_ff;
   logic [THREADS-1:0] queued_ff;
   logic [TID_W-1:0] run_ff;
   logic             runv_ff;
   logic [7:0]       count_ff;
   logic [7:0]       interval_ff;
   logic [LVL_W-1:0] init_ff;
   logic             need_ff, sw_ff, bst_ff;

   // push candidate from the event step
   logic             push_en;
   logic [TID_W-1:0] push_t;
   logic [LVL_W-1:0] push_lv;
   logic             busy;
   logic [LVL_W-1:0] run_lv;
   logic             found;
   logic [LVL_W-1:0] top_lv;
   logic [TID_W-1:0] pop_t;
   logic [7:0]       count_inc;
   localparam logic [LVL_W-1:0] TOP = LVL_W'(LEVELS - 1);

   assign busy   = queued_ff[req_thread_id] || (runv_ff && run_ff == req_thread_id);
   assign run_lv = level_ff[run_ff];

   always_comb begin
      push_en = 1'b0;
      push_t  = run_ff;
      push_lv = run_lv;
      unique case (req_action)
         ACT_ADMIT: begin
            push_en = !busy;
            push_t  = req_thread_id;
            push_lv = init_ff;
         end
         ACT_TICK: begin
            push_en = runv_ff && run_ff != '0;
            push_lv = (run_lv != '0) ? run_lv - 1'b1 : run_lv;
         end
         ACT_YIELD: push_en = runv_ff;
         ACT_WAKE: begin
            push_en = !busy;
            push_t  = req_thread_id;
            push_lv = level_ff[req_thread_id];
         end
         default: push_en = 1'b0;
      endcase
   end

   always_comb begin
      found  = 1'b0;
      top_lv = '0;
      for (int i = 0; i < LEVELS; i++) begin
         if (nonempty_ff[i]) begin
            found  = 1'b1;
            top_lv = LVL_W'(i);
         end
      end
   end

   assign pop_t     = head_ff[top_lv];
   assign count_inc = count_ff + 8'd1;

   assign status.need_grant = need_ff && found;
   assign status.boost_due  = count_inc >= interval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         nonempty_ff <= '0;
         queued_ff   <= '0;
         run_ff      <= '0;
         runv_ff     <= 1'b1;
         count_ff    <= '0;
         interval_ff <= BOOST_RESET;
         init_ff     <= LEVEL_RESET;
         need_ff     <= 1'b0;
         sw_ff       <= 1'b0;
         bst_ff      <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_BOOST_INTERVAL: interval_ff <= csr_data;
               CSR_INITIAL_LEVEL:  init_ff <= csr_data[LVL_W-1:0];
               default: ;
            endcase
         end
         if (cmd.load) begin
            sw_ff   <= 1'b0;
            bst_ff  <= 1'b0;
            need_ff <= 1'b0;
            if (req_action == ACT_ADMIT || req_action == ACT_TICK
                || req_action == ACT_YIELD || req_action == ACT_WAKE) begin
               if (push_en) begin
                  if (req_action != ACT_WAKE) level_ff[push_t] <= push_lv;
                  link_ff[push_t]   <= '0;
                  queued_ff[push_t] <= 1'b1;
                  qlv_ff[push_t]    <= push_lv;
                  if (nonempty_ff[push_lv]) begin
                     link_ff[tail_ff[push_lv]] <= push_t;
                  end else begin
                     head_ff[push_lv] <= push_t;
                  end
                  tail_ff[push_lv]     <= push_t;
                  nonempty_ff[push_lv] <= 1'b1;
               end
            end
            if (req_action == ACT_SETLV) begin
               level_ff[req_thread_id] <= req_new_level;
            end
            if ((req_action == ACT_TICK && !(runv_ff && run_ff == '0))
                || req_action == ACT_YIELD || req_action == ACT_LEAVE) begin
               runv_ff <= 1'b0;
               run_ff  <= '0;
               need_ff <= 1'b1;
            end
         end
         if (cmd.grant) begin
            run_ff    <= pop_t;
            runv_ff   <= 1'b1;
            sw_ff     <= 1'b1;
            queued_ff[pop_t] <= 1'b0;
            if (pop_t == tail_ff[top_lv]) nonempty_ff[top_lv] <= 1'b0;
            else head_ff[top_lv] <= link_ff[pop_t];
            if (status.boost_due) begin
               count_ff <= '0;
               bst_ff   <= 1'b1;
            end else begin
               count_ff <= count_inc;
            end
         end
         if (cmd.boost && nonempty_ff[cmd.boost_level]) begin
            // relevel the threads waiting in the spliced level
            for (int t = 0; t < THREADS; t++) begin
               if (queued_ff[t] && qlv_ff[t] == cmd.boost_level) begin
                  level_ff[t] <= TOP;
                  qlv_ff[t]   <= TOP;
               end
            end
            if (nonempty_ff[TOP]) link_ff[tail_ff[TOP]] <= head_ff[cmd.boost_level];
            else head_ff[TOP] <= head_ff[cmd.boost_level];
            tail_ff[TOP]     <= tail_ff[cmd.boost_level];
            nonempty_ff[TOP] <= 1'b1;
            nonempty_ff[cmd.boost_level] <= 1'b0;
         end
      end
   end

   assign rsp_run_thread = run_ff;
   assign rsp_run_valid  = runv_ff;
   assign rsp_switched   = sw_ff;
   assign rsp_boosted    = bst_ff;

   a_bst_sw: assert property (@(posedge clock) disable iff (reset)
      rsp_boosted |-> rsp_switched) else $error("boost without grant");
   a_grant_run: assert property (@(posedge clock) disable iff (reset)
      cmd.grant |=> runv_ff) else $error("grant left no thread running");
   a_run_notq: assert property (@(posedge clock) disable iff (reset)
      cmd.grant |=> !queued_ff[run_ff]) else $error("running thread still queued");

endmodule

/* rtl/multilevel_feedback_scheduler.sv */
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler
// Event-driven multilevel feedback queue scheduler with periodic boost.
// ----------------------------------------------------------------------------
// One event is handled at a time in the steps capture, grant and reply,
// plus a boost sweep after the grant when it triggers a boost, which splices
// each lower level's list onto the top list one level per cycle. The reply register
// holds until rsp_ready; the next request is taken once it is transferred.
module multilevel_feedback_scheduler
   import mlfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [ACTION_W-1:0]   req_action,
   input  logic [TID_W-1:0]      req_thread_id,
   input  logic [LVL_W-1:0]      req_new_level,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [TID_W-1:0]      rsp_run_thread,
   output logic                  rsp_run_valid,
   output logic                  rsp_switched,
   output logic                  rsp_boosted,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   mlfs_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .status, .cmd
   );

   mlfs_dp u_dp (
      .clock, .reset, .cmd, .status, .req_action, .req_thread_id, .req_new_level,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .rsp_run_thread, .rsp_run_valid, .rsp_switched, .rsp_boosted
   );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multilevel feedback scheduler: a directed table
// and random scheduling events, responses checked against typed table results
// or an in-bench model of level queues, running thread and boost counter.
// ----------------------------------------------------------------------------
module testbench;
   import mlfs_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_SPARE6 = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_SPARE7 = 3'd7;
   localparam int PHASE_ITEMS = 200;
   localparam int PHASES      = 8;
   localparam int WATCH_LIMIT = 3000;

   typedef struct packed {
      logic [TID_W-1:0] run_thread;
      logic             run_valid;
      logic             switched;
      logic             boosted;
   } sched_result_type;

   typedef struct packed {
      logic [ACTION_W-1:0] act;
      logic [TID_W-1:0]    tid;
      logic [LVL_W-1:0]    lvl;
      logic                typed;
      sched_result_type    res;
   } event_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [ACTION_W-1:0]   req_action;
   logic [TID_W-1:0]      req_thread_id;
   logic [LVL_W-1:0]      req_new_level;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [TID_W-1:0]      rsp_run_thread;
   logic                  rsp_run_valid;
   logic                  rsp_switched;
   logic                  rsp_boosted;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   multilevel_feedback_scheduler dut (.*);

   // scheduler mirror
   logic [TID_W-1:0] link_of [THREADS];
   logic [LVL_W-1:0] level_of [THREADS];
   bit               waiting [THREADS];
   bit               level_known [THREADS];
   logic [TID_W-1:0] lv_head [LEVELS];
   logic [TID_W-1:0] lv_tail [LEVELS];
   bit               lv_busy [LEVELS];
   logic [TID_W-1:0] cur_thread;
   bit               cur_valid;
   logic [7:0]       grant_cnt;
   logic [7:0]       cfg_boost;
   logic [LVL_W-1:0] cfg_init;

   sched_result_type expected_q[$];
   int            errors;
   bit            quiet;
   bit            hold_ask;
   int            hold_left;
   int            idle_cycles;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void enqueue(logic [TID_W-1:0] t);
      logic [LVL_W-1:0] lv;
      lv = level_of[t];
      link_of[t] = '0;
      if (lv_busy[lv]) begin
         link_of[lv_tail[lv]] = t;
         lv_tail[lv] = t;
      end else begin
         lv_head[lv] = t;
         lv_tail[lv] = t;
         lv_busy[lv] = 1;
      end
      waiting[t] = 1;
   endfunction

   function automatic logic [TID_W-1:0] dequeue(int lv);
      logic [TID_W-1:0] t;
      t = lv_head[lv];
      if (t == lv_tail[lv]) lv_busy[lv] = 0;
      else lv_head[lv] = link_of[t];
      waiting[t] = 0;
      return t;
   endfunction

   function automatic void boost_levels();
      logic [TID_W-1:0] t;
      for (int lv = 0; lv < LEVELS - 1; lv++) begin
         if (lv_busy[lv]) begin
            t = lv_head[lv];
            for (int n = 0; n < THREADS; n++) begin
               level_of[t] = LVL_W'(LEVELS - 1);
               if (t == lv_tail[lv]) break;
               t = link_of[t];
            end
            if (lv_busy[LEVELS-1]) link_of[lv_tail[LEVELS-1]] = lv_head[lv];
            else lv_head[LEVELS-1] = lv_head[lv];
            lv_tail[LEVELS-1] = lv_tail[lv];
            lv_busy[LEVELS-1] = 1;
            lv_busy[lv] = 0;
         end
      end
   endfunction

   function automatic logic [1:0] grant_next();
      for (int lv = LEVELS - 1; lv >= 0; lv--) begin
         if (lv_busy[lv]) begin
            cur_thread = dequeue(lv);
            cur_valid = 1;
            grant_cnt = grant_cnt + 8'd1;
            if (grant_cnt >= cfg_boost) begin
               boost_levels();
               grant_cnt = '0;
               return 2'b11;
            end
            return 2'b01;
         end
      end
      return 2'b00;
   endfunction

   function automatic bit occupied(logic [TID_W-1:0] t);
      return waiting[t] || (cur_valid && cur_thread == t);
   endfunction

   function automatic sched_result_type schedule(logic [ACTION_W-1:0] a,
                                                 logic [TID_W-1:0] id,
                                                 logic [LVL_W-1:0] nl);
      logic [1:0]       flags;
      sched_result_type r;
      flags = 2'b00;
      case (a)
         ACT_ADMIT: begin
            if (!occupied(id)) begin
               level_of[id] = cfg_init;
               level_known[id] = 1;
               enqueue(id);
            end
         end
         ACT_TICK: begin
            if (!(cur_valid && cur_thread == 0)) begin
               if (cur_valid) begin
                  if (level_of[cur_thread] > 0) level_of[cur_thread]--;
                  enqueue(cur_thread);
                  cur_valid = 0;
                  cur_thread = '0;
               end
               flags = grant_next();
            end
         end
         ACT_YIELD: begin
            if (cur_valid) begin
               enqueue(cur_thread);
               cur_valid = 0;
               cur_thread = '0;
            end
            flags = grant_next();
         end
         ACT_LEAVE: begin
            cur_valid = 0;
            cur_thread = '0;
            flags = grant_next();
         end
         ACT_WAKE: begin
            if (!occupied(id)) enqueue(id);
         end
         ACT_SETLV: begin
            level_of[id] = nl;
            level_known[id] = 1;
         end
         default: ;
      endcase
      r.run_thread = cur_valid ? cur_thread : '0;
      r.run_valid  = cur_valid;
      r.switched   = flags[0];
      r.boosted    = flags[1];
      return r;
   endfunction

   // keep events off threads whose level was never written
   function automatic void legalize(inout logic [ACTION_W-1:0] a, inout logic [TID_W-1:0] id);
      if (a == ACT_WAKE && !level_known[id] && !occupied(id)) a = ACT_SETLV;
      if ((a == ACT_YIELD || (a == ACT_TICK && cur_thread != 0)) && cur_valid
          && !level_known[cur_thread]) begin
         a = ACT_SETLV;
         id = cur_thread;
      end
   endfunction

   task automatic offer(logic [ACTION_W-1:0] a, logic [TID_W-1:0] id, logic [LVL_W-1:0] nl,
                        bit typed, sched_result_type typed_res);
      sched_result_type r;
      r = schedule(a, id, nl);
      expected_q.push_back(typed ? typed_res : r);
      req_valid     <= 1'b1;
      req_action    <= a;
      req_thread_id <= id;
      req_new_level <= nl;
      do @(posedge clock); while (!req_ready);
      if (!quiet && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_BOOST_INTERVAL) cfg_boost = val;
      else cfg_init = val[LVL_W-1:0];
   endtask

   task automatic random_event();
      logic [ACTION_W-1:0] a;
      logic [TID_W-1:0]    id;
      logic [LVL_W-1:0]    nl;
      int                  pick;
      pick = $urandom_range(99);
      id = TID_W'($urandom_range(THREADS - 1));
      nl = LVL_W'($urandom_range(LEVELS - 1));
      if (pick < 25) a = ACT_ADMIT;
      else if (pick < 45) a = ACT_TICK;
      else if (pick < 60) a = ACT_YIELD;
      else if (pick < 72) a = ACT_LEAVE;
      else if (pick < 85) a = ACT_WAKE;
      else if (pick < 95) a = ACT_SETLV;
      else a = pick[0] ? ACT_SPARE7 : ACT_SPARE6;
      legalize(a, id);
      offer(a, id, nl, 1'b0, '0);
   endtask

   // receiver
   initial begin
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_ask) begin
            hold_ask = 0;
            hold_left = 400;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet || ($urandom_range(99) >= 21);
         end
      end
   end

   always @(posedge clock) begin
      sched_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response run_thread=%0d run_valid=%0b", $time,
                     rsp_run_thread, rsp_run_valid);
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_run_thread !== e.run_thread) begin
               $display("%0t: run_thread expected %0d actual %0d", $time, e.run_thread,
                        rsp_run_thread);
               errors++;
            end
            if (rsp_run_valid !== e.run_valid) begin
               $display("%0t: run_valid expected %0b actual %0b", $time, e.run_valid,
                        rsp_run_valid);
               errors++;
            end
            if (rsp_switched !== e.switched) begin
               $display("%0t: switched expected %0b actual %0b", $time, e.switched,
                        rsp_switched);
               errors++;
            end
            if (rsp_boosted !== e.boosted) begin
               $display("%0t: boosted expected %0b actual %0b", $time, e.boosted,
                        rsp_boosted);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCH_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      event_row_type rows[$];
      rows = '{
         '{ACT_TICK,   4'd0,  2'd0, 1'b1, '{4'd0, 1'b1, 1'b0, 1'b0}},
         '{ACT_SPARE6, 4'd9,  2'd1, 1'b1, '{4'd0, 1'b1, 1'b0, 1'b0}},
         '{ACT_SPARE7, 4'd3,  2'd2, 1'b1, '{4'd0, 1'b1, 1'b0, 1'b0}},
         '{ACT_ADMIT,  4'd15, 2'd0, 1'b1, '{4'd0, 1'b1, 1'b0, 1'b0}},
         '{ACT_ADMIT,  4'd1,  2'd0, 1'b1, '{4'd0, 1'b1, 1'b0, 1'b0}},
         '{ACT_SETLV,  4'd1,  2'd0, 1'b1, '{4'd0, 1'b1, 1'b0, 1'b0}},
         '{ACT_SETLV,  4'd15, 2'd3, 1'b1, '{4'd0, 1'b1, 1'b0, 1'b0}},
         '{ACT_LEAVE,  4'd0,  2'd0, 1'b1, '{4'd15, 1'b1, 1'b1, 1'b0}},
         '{ACT_TICK,   4'd0,  2'd0, 1'b0, '0},
         '{ACT_YIELD,  4'd0,  2'd0, 1'b0, '0},
         '{ACT_WAKE,   4'd1,  2'd0, 1'b0, '0},
         '{ACT_ADMIT,  4'd0,  2'd0, 1'b0, '0},
         '{ACT_LEAVE,  4'd0,  2'd0, 1'b0, '0},
         '{ACT_LEAVE,  4'd0,  2'd0, 1'b0, '0},
         '{ACT_LEAVE,  4'd0,  2'd0, 1'b1, '{4'd0, 1'b0, 1'b0, 1'b0}},
         '{ACT_TICK,   4'd0,  2'd0, 1'b1, '{4'd0, 1'b0, 1'b0, 1'b0}},
         '{ACT_YIELD,  4'd0,  2'd0, 1'b1, '{4'd0, 1'b0, 1'b0, 1'b0}},
         '{ACT_SETLV,  4'd2,  2'd3, 1'b0, '0},
         '{ACT_WAKE,   4'd2,  2'd0, 1'b0, '0},
         '{ACT_ADMIT,  4'd3,  2'd0, 1'b0, '0},
         '{ACT_TICK,   4'd0,  2'd0, 1'b0, '0},
         '{ACT_TICK,   4'd0,  2'd0, 1'b0, '0},
         '{ACT_YIELD,  4'd0,  2'd0, 1'b0, '0}
      };
      errors = 0;
      quiet = 0;
      hold_ask = 0;
      for (int t = 0; t < THREADS; t++) begin
         link_of[t] = '0;
         level_of[t] = '0;
         waiting[t] = 0;
         level_known[t] = 0;
      end
      for (int lv = 0; lv < LEVELS; lv++) begin
         lv_head[lv] = '0;
         lv_tail[lv] = '0;
         lv_busy[lv] = 0;
      end
      cur_thread = '0;
      cur_valid = 1;
      grant_cnt = '0;
      cfg_boost = BOOST_RESET;
      cfg_init = LEVEL_RESET;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_action    <= ACT_ADMIT;
      req_thread_id <= '0;
      req_new_level <= '0;
      csr_valid     <= 1'b0;
      csr_index     <= CSR_BOOST_INTERVAL;
      csr_data      <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) offer(rows[i].act, rows[i].tid, rows[i].lvl, rows[i].typed, rows[i].res);
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin write_reg(CSR_BOOST_INTERVAL, 8'd1); write_reg(CSR_INITIAL_LEVEL, 8'd0); end
            1: begin write_reg(CSR_BOOST_INTERVAL, 8'd255); write_reg(CSR_INITIAL_LEVEL, 8'd3); end
            2: begin write_reg(CSR_BOOST_INTERVAL, 8'd0); write_reg(CSR_INITIAL_LEVEL, 8'd2); end
            default: begin
               write_reg(CSR_BOOST_INTERVAL, 8'($urandom_range(1, 20)));
               write_reg(CSR_INITIAL_LEVEL, 8'($urandom_range(LEVELS - 1)));
            end
         endcase
         quiet = (ph == 5);
         if (ph == 3) hold_ask = 1;
         for (int n = 0; n < PHASE_ITEMS; n++) random_event();
         drain();
      end
      quiet = 0;

      if (errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
